FILE: rtl/awd_pkg.sv
package awd_pkg;

    // component width and derived widths
    localparam int COMP_WIDTH = 16;
    localparam int MAG_W      = COMP_WIDTH + 1;
    localparam int T_W        = 16;
    localparam int N_W        = MAG_W + 15;
    localparam int S_W        = 18;
    localparam int ACC_W      = 20;
    localparam int ANG_W      = 21;
    localparam int PROD_W     = ANG_W + 16;
    localparam int DIR_W      = 16;
    localparam int S_TDATA_W  = ((2 * COMP_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DIR_W + 7) / 8) * 8;
    localparam int N_HORNER   = 5;

    // atan polynomial coefficients, Q1.17
    localparam logic signed [ACC_W-1:0] C_A11 = -ACC_W'(1536);
    localparam logic signed [ACC_W-1:0] C_A9  = ACC_W'(6901);
    localparam logic signed [ACC_W-1:0] C_A7  = -ACC_W'(15261);
    localparam logic signed [ACC_W-1:0] C_A5  = ACC_W'(25368);
    localparam logic signed [ACC_W-1:0] C_A3  = -ACC_W'(43598);
    localparam logic signed [ACC_W-1:0] C_A1  = ACC_W'(131069);

    // angle constants, Q1.17 radians
    localparam logic signed [ANG_W-1:0] HALF_PI_Q17 = ANG_W'(205887);
    localparam logic signed [ANG_W-1:0] PI_Q17      = ANG_W'(411775);

    // radians to 1/128 degree scale, split in two partial products
    localparam longint DEG_K  = 64'd480631834;
    localparam int     K_HI   = int'(DEG_K / 32768);
    localparam int     K_LO   = int'(DEG_K % 32768);

    localparam logic [DIR_W-1:0] DIR_CENTER = DIR_W'(23040);
    localparam logic [DIR_W-1:0] DIR_MAX    = DIR_W'(46080);

    // per-request flags that travel beside the data
    typedef struct packed {
        logic last;
        logic zero;
        logic swap;
        logic xneg;
        logic yneg;
    } awd_side_t;

    // horner coefficient for step k (k = 0 uses a9)
    function automatic logic signed [ACC_W-1:0] horner_coef(input int k);
        logic signed [ACC_W-1:0] c;
        unique case (k)
            0: c = C_A9;
            1: c = C_A7;
            2: c = C_A5;
            3: c = C_A3;
            default: c = C_A1;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/awd_div.sv
module awd_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      ce,
    input  logic                      in_valid,
    input  awd_pkg::awd_side_t        in_side,
    input  logic [awd_pkg::MAG_W-1:0] num,
    input  logic [awd_pkg::MAG_W-1:0] den,
    output logic                      out_valid,
    output awd_pkg::awd_side_t        out_side,
    output logic [awd_pkg::T_W-1:0]   quot
);
    import awd_pkg::*;

    logic [N_W-1:0] dividend;

    // per-stage inputs, index 0 is the entry
    logic             w_valid [0:T_W];
    awd_side_t        w_side  [0:T_W];
    logic [MAG_W-1:0] w_rem   [0:T_W];
    logic [MAG_W-1:0] w_den   [0:T_W];
    logic [T_W-1:0]   w_low   [0:T_W];
    logic [T_W-1:0]   w_quot  [0:T_W];

    // rounded dividend: num * 2^15 + den / 2
    assign dividend = (N_W'(num) << 15) + N_W'(den >> 1);

    assign w_valid[0] = in_valid;
    assign w_side[0]  = in_side;
    assign w_rem[0]   = MAG_W'(dividend[N_W-1:T_W]);
    assign w_den[0]   = den;
    assign w_low[0]   = dividend[T_W-1:0];
    assign w_quot[0]  = '0;

    // one quotient bit per stage
    for (genvar i = 0; i < T_W; i++) begin : g_stage
        logic             valid_reg;
        awd_side_t        side_reg;
        logic [MAG_W-1:0] rem_reg, rem_next;
        logic [MAG_W-1:0] den_reg;
        logic [T_W-1:0]   low_reg;
        logic [T_W-1:0]   quot_reg, quot_next;
        logic [MAG_W:0]   trial;
        logic [MAG_W:0]   diff;

        always_comb begin
            trial = {w_rem[i], w_low[i][T_W-1-i]};
            diff  = trial - {1'b0, w_den[i]};
            if (trial >= {1'b0, w_den[i]}) begin
                rem_next  = diff[MAG_W-1:0];
                quot_next = {w_quot[i][T_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[MAG_W-1:0];
                quot_next = {w_quot[i][T_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg <= 1'b0;
            end else if (ce) begin
                valid_reg <= w_valid[i];
            end
            if (ce) begin
                side_reg <= w_side[i];
                rem_reg  <= rem_next;
                den_reg  <= w_den[i];
                low_reg  <= w_low[i];
                quot_reg <= quot_next;
            end
        end

        assign w_valid[i+1] = valid_reg;
        assign w_side[i+1]  = side_reg;
        assign w_rem[i+1]   = rem_reg;
        assign w_den[i+1]   = den_reg;
        assign w_low[i+1]   = low_reg;
        assign w_quot[i+1]  = quot_reg;
    end

    assign out_valid = w_valid[T_W];
    assign out_side  = w_side[T_W];
    assign quot      = w_quot[T_W];

endmodule

FILE: rtl/awd_poly.sv
module awd_poly (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             ce,
    input  logic                             in_valid,
    input  awd_pkg::awd_side_t               in_side,
    input  logic [awd_pkg::T_W-1:0]          t,
    output logic                             out_valid,
    output awd_pkg::awd_side_t               out_side,
    output logic signed [awd_pkg::ACC_W-1:0] theta
);
    import awd_pkg::*;

    logic [2*T_W-1:0] tsq;
    logic             sq_valid_reg;
    awd_side_t        sq_side_reg;
    logic [T_W-1:0]   sq_t_reg;
    logic [S_W-1:0]   sq_s_reg;

    logic                    h_valid [0:N_HORNER];
    awd_side_t               h_side  [0:N_HORNER];
    logic [T_W-1:0]          h_t     [0:N_HORNER];
    logic [S_W-1:0]          h_s     [0:N_HORNER];
    logic signed [ACC_W-1:0] h_acc   [0:N_HORNER];

    logic signed [ACC_W+T_W:0] th_prod;
    logic                      th_valid_reg;
    awd_side_t                 th_side_reg;
    logic signed [ACC_W-1:0]   th_reg;

    // square of the ratio, Q2.30 (stored in sq_s_reg as Q1.17)
    assign tsq = T_W'(t) * T_W'(t);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (ce) begin
            sq_valid_reg <= in_valid;
        end
        if (ce) begin
            sq_side_reg <= in_side;
            sq_t_reg    <= t;
            sq_s_reg    <= S_W'((tsq + (2*T_W)'(4096)) >> 13);
        end
    end

    assign h_valid[0] = sq_valid_reg;
    assign h_side[0]  = sq_side_reg;
    assign h_t[0]     = sq_t_reg;
    assign h_s[0]     = sq_s_reg;
    assign h_acc[0]   = C_A11;

    // horner steps, one multiply per stage
    for (genvar k = 0; k < N_HORNER; k++) begin : g_horner
        logic signed [ACC_W+S_W:0] prod;
        logic signed [ACC_W+S_W:0] rnd;
        logic                      valid_reg;
        awd_side_t                 side_reg;
        logic [T_W-1:0]            t_reg;
        logic [S_W-1:0]            s_reg;
        logic signed [ACC_W-1:0]   acc_reg;

        assign prod = h_acc[k] * $signed({1'b0, h_s[k]});
        assign rnd  = (prod + (ACC_W+S_W+1)'(65536)) >>> 17;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg <= 1'b0;
            end else if (ce) begin
                valid_reg <= h_valid[k];
            end
            if (ce) begin
                side_reg <= h_side[k];
                t_reg    <= h_t[k];
                s_reg    <= h_s[k];
                acc_reg  <= rnd[ACC_W-1:0] + horner_coef(k);
            end
        end

        assign h_valid[k+1] = valid_reg;
        assign h_side[k+1]  = side_reg;
        assign h_t[k+1]     = t_reg;
        assign h_s[k+1]     = s_reg;
        assign h_acc[k+1]   = acc_reg;
    end

    // theta = t * poly, back to Q1.17
    assign th_prod = (h_acc[N_HORNER] * $signed({1'b0, h_t[N_HORNER]}))
                     + (ACC_W+T_W+1)'(16384);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            th_valid_reg <= 1'b0;
        end else if (ce) begin
            th_valid_reg <= h_valid[N_HORNER];
        end
        if (ce) begin
            th_side_reg <= h_side[N_HORNER];
            th_reg      <= ACC_W'(th_prod >>> 15);
        end
    end

    assign out_valid = th_valid_reg;
    assign out_side  = th_side_reg;
    assign theta     = th_reg;

endmodule

FILE: rtl/awd_ang.sv
module awd_ang (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             ce,
    input  logic                             in_valid,
    input  awd_pkg::awd_side_t               in_side,
    input  logic signed [awd_pkg::ACC_W-1:0] theta,
    output logic                             out_valid,
    output logic                             out_last,
    output logic [awd_pkg::DIR_W-1:0]        direction
);
    import awd_pkg::*;

    localparam int SUM_W = PROD_W + 16;

    logic signed [ANG_W-1:0]  a_oct, a_quad, ang_next;
    logic                     q_valid_reg;
    awd_side_t                q_side_reg;
    logic signed [ANG_W-1:0]  ang_reg;

    logic                     m_valid_reg;
    awd_side_t                m_side_reg;
    logic signed [PROD_W-1:0] ph_reg, pl_reg;

    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  dir_full;
    logic [DIR_W-1:0]         dir_next;
    logic                     o_valid_reg;
    logic                     o_last_reg;
    logic [DIR_W-1:0]         dir_reg;

    // octant swap, quadrant and sign correction
    always_comb begin
        a_oct    = in_side.swap ? (HALF_PI_Q17 - ANG_W'(theta)) : ANG_W'(theta);
        a_quad   = in_side.xneg ? (PI_Q17 - a_oct) : a_oct;
        ang_next = in_side.yneg ? -a_quad : a_quad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (ce) begin
            q_valid_reg <= in_valid;
        end
        if (ce) begin
            q_side_reg <= in_side;
            ang_reg    <= ang_next;
        end
    end

    // partial products of the degree scale
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= q_valid_reg;
        end
        if (ce) begin
            m_side_reg <= q_side_reg;
            ph_reg     <= ang_reg * $signed({1'b0, 15'(K_HI)});
            pl_reg     <= ang_reg * $signed({1'b0, 15'(K_LO)});
        end
    end

    // recombine, round, center and clamp; a zero vector gives DIR_CENTER
    always_comb begin
        sum      = (SUM_W'(ph_reg) <<< 15) + SUM_W'(pl_reg)
                   + (SUM_W'(1) <<< 32);
        dir_full = (sum >>> 33) + $signed(SUM_W'(DIR_CENTER));
        if (m_side_reg.zero) begin
            dir_next = DIR_CENTER;
        end else if (dir_full < 0) begin
            dir_next = '0;
        end else if (dir_full > $signed(SUM_W'(DIR_MAX))) begin
            dir_next = DIR_MAX;
        end else begin
            dir_next = dir_full[DIR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (ce) begin
            o_valid_reg <= m_valid_reg;
        end
        if (ce) begin
            o_last_reg <= m_side_reg.last;
            dir_reg    <= dir_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_last  = o_last_reg;
    assign direction = dir_reg;

endmodule

FILE: rtl/wind_direction_atan2.sv
// wind direction from a wind vector, atan2 based
// throughput: one request per cycle while the result side is not stalled; the divider is radix-2
// a stall on the result side holds the whole pipeline, nothing lost or repeated
// reset: aresetn synchronous active low, clears all valid bits
module wind_direction_atan2 (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // y_comp, x_comp
    input  logic [awd_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // direction
    output logic [awd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);
    import awd_pkg::*;

    logic ce;

    logic [COMP_WIDTH-1:0] y_in, x_in;
    logic signed [MAG_W-1:0] y_ext, x_ext;
    logic [MAG_W-1:0] ay, ax;
    awd_side_t side_next;

    logic             in_valid_reg;
    awd_side_t        in_side_reg;
    logic [MAG_W-1:0] num_reg, den_reg;

    logic                    div_valid;
    awd_side_t               div_side;
    logic [T_W-1:0]          div_q;
    logic                    poly_valid;
    awd_side_t               poly_side;
    logic signed [ACC_W-1:0] poly_theta;
    logic [DIR_W-1:0]        dir;

    // pipeline advances unless a result is held
    assign ce       = m_tready | ~m_tvalid;
    assign s_tready = ce;

    // magnitudes and octant selection
    always_comb begin
        y_in  = s_tdata[COMP_WIDTH-1:0];
        x_in  = s_tdata[2*COMP_WIDTH-1:COMP_WIDTH];
        y_ext = $signed({y_in[COMP_WIDTH-1], y_in});
        x_ext = $signed({x_in[COMP_WIDTH-1], x_in});
        ay    = y_in[COMP_WIDTH-1] ? MAG_W'(-y_ext) : MAG_W'(y_ext);
        ax    = x_in[COMP_WIDTH-1] ? MAG_W'(-x_ext) : MAG_W'(x_ext);
        side_next.last = s_tlast;
        side_next.zero = (ax == '0) && (ay == '0);
        side_next.swap = ax < ay;
        side_next.xneg = x_in[COMP_WIDTH-1];
        side_next.yneg = y_in[COMP_WIDTH-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (ce) begin
            in_valid_reg <= s_tvalid;
        end
        if (ce) begin
            in_side_reg <= side_next;
            num_reg     <= side_next.swap ? ax : ay;
            den_reg     <= side_next.swap ? ay : ax;
        end
    end

    awd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (in_valid_reg),
        .in_side   (in_side_reg),
        .num       (num_reg),
        .den       (den_reg),
        .out_valid (div_valid),
        .out_side  (div_side),
        .quot      (div_q)
    );

    awd_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (div_valid),
        .in_side   (div_side),
        .t         (div_q),
        .out_valid (poly_valid),
        .out_side  (poly_side),
        .theta     (poly_theta)
    );

    awd_ang u_ang (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (poly_valid),
        .in_side   (poly_side),
        .theta     (poly_theta),
        .out_valid (m_tvalid),
        .out_last  (m_tlast),
        .direction (dir)
    );

    assign m_tdata = M_TDATA_W'(dir);

endmodule

FILE: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import awd_pkg::*;

    typedef struct packed {
        logic              last;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } wind_point_t;

    typedef struct packed {
        logic [15:0] dir;
        logic        last;
    } heading_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic s_tready_q = 1'b0;

    wind_point_t pending_points[$];
    heading_t    expected_headings[$];
    int send_idle_pct = 19;
    int recv_idle_pct = 74;
    bit hold_send = 1'b0;
    int mismatches = 0;
    int headings_seen = 0;
    int points_sent = 0;

    wind_direction_atan2 i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #10 aclk = ~aclk;

    // round half up by 2^n, floor semantics
    function automatic longint round_shift(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // expected direction in 1/128 degree
    function automatic logic [15:0] predict_heading(input logic signed [15:0] y,
                                                   input logic signed [15:0] x);
        longint ay, ax, num, den, t, s, acc, theta, a, dir;
        bit swp;
        ay = (y < 0) ? -longint'(y) : longint'(y);
        ax = (x < 0) ? -longint'(x) : longint'(x);
        if (ax == 0 && ay == 0) return DIR_CENTER;
        swp = ax < ay;
        num = swp ? ax : ay;
        den = swp ? ay : ax;
        t = (num * 32768 + den / 2) / den;
        s = (t * t + 4096) >>> 13;
        acc = C_A11;
        acc = round_shift(acc * s, 17) + C_A9;
        acc = round_shift(acc * s, 17) + C_A7;
        acc = round_shift(acc * s, 17) + C_A5;
        acc = round_shift(acc * s, 17) + C_A3;
        acc = round_shift(acc * s, 17) + C_A1;
        theta = round_shift(t * acc, 15);
        a = swp ? (longint'(HALF_PI_Q17) - theta) : theta;
        if (x < 0) a = longint'(PI_Q17) - a;
        if (y < 0) a = -a;
        dir = round_shift(a * DEG_K, 33) + 23040;
        if (dir < 0) dir = 0;
        if (dir > 46080) dir = 46080;
        return dir[15:0];
    endfunction

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 6)) - 3);
            3: return 16'(int'($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_q) begin
                if (pending_points.size() > 0 && !hold_send &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    wind_point_t p;
                    p = pending_points.pop_front();
                    s_tdata  <= {p.x, p.y};
                    s_tlast  <= p.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // acceptance seen at the rising edge
    always @(posedge aclk) begin
        s_tready_q <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            heading_t h;
            h.dir  = predict_heading(s_tdata[15:0], s_tdata[31:16]);
            h.last = s_tlast;
            expected_headings.push_back(h);
            points_sent++;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            heading_t e;
            headings_seen++;
            if (expected_headings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result dir=%0d", m_tdata[15:0]);
            end else begin
                e = expected_headings.pop_front();
                if (m_tdata[15:0] !== e.dir || m_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected dir=%0d last=%0b, got dir=%0d last=%0b",
                                 e.dir, e.last, m_tdata[15:0], m_tlast);
                end
            end
        end
    end

    task automatic add_point(input logic [15:0] y, input logic [15:0] x, input logic l);
        wind_point_t p;
        p.y = y;
        p.x = x;
        p.last = l;
        pending_points.push_back(p);
    endtask

    task automatic drain_phase();
        wait (pending_points.size() == 0);
        hold_send = 1'b1;
        @(negedge aclk);
        @(negedge aclk);
        while (s_tvalid || expected_headings.size() > 0) @(negedge aclk);
        hold_send = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero vector, axes, diagonals, extremes
        add_point(16'h0000, 16'h0000, 1'b0);
        add_point(16'h0000, 16'hFFFF, 1'b0);
        add_point(16'h0000, 16'h8000, 1'b1);
        add_point(16'h0000, 16'h7FFF, 1'b0);
        add_point(16'h7FFF, 16'h0000, 1'b0);
        add_point(16'h8000, 16'h0000, 1'b0);
        add_point(16'h0001, 16'h0001, 1'b1);
        add_point(16'hFFFF, 16'hFFFF, 1'b0);
        add_point(16'h8000, 16'h8000, 1'b0);
        add_point(16'h7FFF, 16'h7FFF, 1'b1);
        add_point(16'h7FFF, 16'h8000, 1'b0);
        add_point(16'h8000, 16'h7FFF, 1'b0);
        add_point(16'h0001, 16'h8000, 1'b0);
        add_point(16'hFFFF, 16'h8000, 1'b1);
        add_point(16'h8000, 16'h0001, 1'b0);
        add_point(16'h0001, 16'h7FFF, 1'b0);
        add_point(16'hAAAA, 16'h5555, 1'b1);
        add_point(16'h5555, 16'hAAAA, 1'b0);
        add_point(16'h0003, 16'hFFFD, 1'b0);
        add_point(16'hFFFE, 16'h0002, 1'b1);

        // random phases with different idling mixes
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 74 : 0;
            recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 19 : 0;
            for (int i = 0; i < 300; i++)
                add_point(pick_comp(), pick_comp(), 1'($urandom_range(0, 1)));
            drain_phase();
        end
        repeat (60) @(posedge aclk);
        $display("covered %0d wind vectors incl. axes, zero vector and full-scale corners",
                 points_sent);
        $display("checked %0d directions under three stall mixes", headings_seen);
        if (mismatches == 0 && expected_headings.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: files.f
rtl/awd_pkg.sv
rtl/awd_div.sv
rtl/awd_poly.sv
rtl/awd_ang.sv
rtl/wind_direction_atan2.sv
bench/testbench.sv
